@@ hdl/lfbg_pkg.sv @@
// Shared types, codes and helpers for the LED frame blend and gamma encoder.
`timescale 1ns / 1ps
package lfbg_pkg;

  typedef enum logic [1:0] {
    OP_SET_PIXEL  = 2'd0,
    OP_COMMIT     = 2'd1,
    OP_LOAD_GAMMA = 2'd2,
    OP_LOAD_MAP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_BLEND_FRAMES = 2'd0,
    CFG_NUM_OUTPUTS  = 2'd1,
    CFG_GAMMA_ENABLE = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] CH_NONE = 2'd3;
  localparam logic [7:0] ENC_IDLE = 8'h80;
  localparam logic [2:0] GAMMA_ENABLE_RESET = 3'd7;

  typedef struct packed {
    logic [3:0] blend_frames;
    logic [8:0] num_outputs;
    logic [2:0] gamma_enable;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] index;
    logic [1:0] channel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] table_value;
    logic       map_skip;
  } cmd_t;

  typedef struct packed {
    logic       written;
    logic [7:0] physical_led;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic [7:0] blue_byte;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic res_push;
  } back_stat_t;

  function automatic logic [7:0] encode(input logic [7:0] v);
    encode = {1'b1, v[7:1]};
  endfunction

endpackage

@@ hdl/lfbg_fifo.sv @@
// Small show-ahead queue built from registers.
`timescale 1ns / 1ps
module lfbg_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

@@ hdl/lfbg_front.sv @@
// Front end: accept items, classify them and queue commands for the back end.
`timescale 1ns / 1ps
module lfbg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [7:0]          index,
  input  logic [1:0]          channel,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [7:0]          table_value,
  input  logic                map_skip,
  input  logic                clearing,
  input  logic                cmd_pop,
  output lfbg_pkg::cmd_t      cmd,
  output logic                cmd_empty
);
  import lfbg_pkg::*;

  cmd_t cmd_in;
  logic q_full;
  logic accept;
  logic enq;
  logic [$bits(cmd_t)-1:0] q_out;

  assign full   = q_full || clearing;
  assign accept = push && !full;

  always_comb begin
    cmd_in.op          = op_t'(operation);
    cmd_in.index       = index;
    cmd_in.channel     = channel;
    cmd_in.red         = red;
    cmd_in.green       = green;
    cmd_in.blue        = blue;
    cmd_in.table_value = table_value;
    cmd_in.map_skip    = map_skip;
    // drop gamma loads aimed at no channel
    enq = accept && !(cmd_in.op == OP_LOAD_GAMMA && channel == CH_NONE);
  end

  lfbg_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmdq (
    .clk(clk), .rst(rst),
    .wr_en(enq), .wr_data(cmd_in), .full(q_full),
    .rd_en(cmd_pop), .rd_data(q_out), .empty(cmd_empty)
  );

  assign cmd = cmd_t'(q_out);
endmodule

@@ hdl/lfbg_div.sv @@
// Three-lane restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lfbg_div #(
  parameter int SW = 12,
  parameter int NW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SW-1:0] dividend [3],
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [7:0]    quot [3]
);
  localparam int KW = $clog2(SW + 1);

  logic [SW-1:0] q   [3];
  logic [NW-1:0] rem [3];
  logic [NW-1:0] d;
  logic [KW-1:0] cnt;
  logic          busy;
  logic [NW:0]   sh  [3];
  logic          ge  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i]   = {rem[i], q[i][SW-1]};
      ge[i]   = sh[i] >= {1'b0, d};
      quot[i] = q[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        d    <= divisor;
        for (int i = 0; i < 3; i++) begin
          q[i]   <= dividend[i];
          rem[i] <= '0;
        end
      end else if (busy) begin
        for (int i = 0; i < 3; i++) begin
          q[i]   <= {q[i][SW-2:0], ge[i]};
          rem[i] <= ge[i] ? NW'(sh[i] - {1'b0, d}) : sh[i][NW-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == KW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/lfbg_back.sv @@
// Back end: map lookup, frame history blend, gamma and byte encoding.
`timescale 1ns / 1ps
module lfbg_back #(
  parameter int MAX_LEDS = 256,
  parameter int MAX_FRAMES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lfbg_pkg::cfg_t        cfg,
  input  lfbg_pkg::cmd_t        cmd,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output lfbg_pkg::res_t        res,
  output lfbg_pkg::back_stat_t  stat
);
  import lfbg_pkg::*;

  localparam int HD  = MAX_FRAMES * MAX_LEDS;
  localparam int AW  = (HD > 1) ? $clog2(HD) : 1;
  localparam int NW  = $clog2(MAX_FRAMES + 1);
  localparam int SLW = $clog2(MAX_FRAMES);
  localparam int SW  = 8 + NW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MAP, ST_HIST, ST_DIV, ST_GAMMA, ST_OUT
  } state_t;

  state_t         state;
  cmd_t           cur;
  logic [AW-1:0]  clr_addr;
  logic [SLW-1:0] slot;
  logic [NW-1:0]  n;
  logic [NW-1:0]  f;
  logic [1:0]     k;
  logic [SW-1:0]  sums [3];
  logic [7:0]     c [3];
  logic [7:0]     phys;
  logic           res_wr;
  logic           div_go;

  logic [23:0] hist_mem [HD];
  logic [23:0] hist_q;
  logic        hist_we;
  logic [AW-1:0] hist_waddr;
  logic [AW-1:0] hist_raddr;
  logic [23:0] hist_wdata;

  logic [8:0]  map_mem [256];
  logic [255:0] map_vld;
  logic [8:0]  map_q;
  logic        map_vld_q;
  logic        map_re;
  logic        map_we;

  logic [7:0]  gamma_mem [768];
  logic [7:0]  gamma_q;
  logic        gamma_we;
  logic [9:0]  gamma_raddr;
  logic [7:0]  gamma_sel;

  logic        pixel_ok;
  logic        div_done;
  logic [7:0]  quot [3];

  always_comb begin
    if (int'(cfg.blend_frames) > MAX_FRAMES) begin
      n = NW'(MAX_FRAMES);
    end else if (cfg.blend_frames < 4'd2) begin
      n = '0;
    end else begin
      n = NW'(cfg.blend_frames);
    end
  end

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty;
  assign map_re  = cmd_pop && cmd.op == OP_SET_PIXEL;
  assign map_we  = cmd_pop && cmd.op == OP_LOAD_MAP;
  assign gamma_we = cmd_pop && cmd.op == OP_LOAD_GAMMA;

  assign pixel_ok = ({1'b0, cur.index} < cfg.num_outputs) && map_vld_q && !map_q[8]
                    && (int'(map_q[7:0]) < MAX_LEDS);

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = clr_addr;
    hist_wdata = '0;
    if (state == ST_CLEAR) begin
      hist_we = 1'b1;
    end else if (state == ST_MAP && pixel_ok && n != '0) begin
      hist_we    = 1'b1;
      hist_waddr = AW'(int'(slot) * MAX_LEDS + int'(map_q[7:0]));
      hist_wdata = {cur.red, cur.green, cur.blue};
    end
    hist_raddr = AW'(int'(f) * MAX_LEDS + int'(phys));
  end

  always_comb begin
    unique case (k)
      2'd0:    gamma_sel = c[0];
      2'd1:    gamma_sel = c[1];
      default: gamma_sel = c[2];
    endcase
    gamma_raddr = {k, gamma_sel};
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[cmd.index] <= {cmd.map_skip, cmd.map_skip ? 8'h00 : cmd.table_value};
    end
    if (map_re) begin
      map_q <= map_mem[cmd.index];
    end
  end

  always_ff @(posedge clk) begin
    if (gamma_we) begin
      gamma_mem[{cmd.channel, cmd.index}] <= cmd.table_value;
    end
    gamma_q <= gamma_mem[gamma_raddr];
  end

  lfbg_div #(.SW(SW), .NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_go),
    .dividend(sums), .divisor(n), .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      slot      <= '0;
      map_vld   <= '0;
      map_vld_q <= 1'b0;
      div_go    <= 1'b0;
      res_wr    <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (map_re) begin
        map_vld_q <= map_vld[cmd.index];
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(HD - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!cmd_empty) begin
            cur <= cmd;
            unique case (cmd.op)
              OP_COMMIT: begin
                if (n != '0) begin
                  slot <= (NW'(slot) + 1'b1 >= n) ? '0 : slot + 1'b1;
                end
              end
              OP_LOAD_MAP:   map_vld[cmd.index] <= 1'b1;
              OP_LOAD_GAMMA: ;
              OP_SET_PIXEL:  state <= ST_MAP;
            endcase
          end
        end
        ST_MAP: begin
          phys <= map_q[7:0];
          c[0] <= cur.red;
          c[1] <= cur.green;
          c[2] <= cur.blue;
          f    <= '0;
          k    <= '0;
          for (int i = 0; i < 3; i++) begin
            sums[i] <= '0;
          end
          priority if (!pixel_ok) begin
            res_wr <= 1'b0;
            state  <= ST_OUT;
          end else if (n == '0) begin
            state <= ST_GAMMA;
          end else begin
            state <= ST_HIST;
          end
        end
        ST_HIST: begin
          if (f != '0) begin
            sums[0] <= sums[0] + SW'(hist_q[23:16]);
            sums[1] <= sums[1] + SW'(hist_q[15:8]);
            sums[2] <= sums[2] + SW'(hist_q[7:0]);
          end
          if (f == n) begin
            div_go <= 1'b1;
            state  <= ST_DIV;
          end else begin
            f <= f + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            for (int i = 0; i < 3; i++) begin
              c[i] <= quot[i];
            end
            state <= ST_GAMMA;
          end
        end
        ST_GAMMA: begin
          if (k != 2'd0 && cfg.gamma_enable[k - 2'd1]) begin
            c[k - 2'd1] <= gamma_q;
          end
          if (k == 2'd3) begin
            res_wr <= 1'b1;
            state  <= ST_OUT;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_OUT: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res.written      = res_wr;
    res.physical_led = res_wr ? phys : 8'h00;
    res.green_byte   = res_wr ? encode(c[1]) : ENC_IDLE;
    res.red_byte     = res_wr ? encode(c[0]) : ENC_IDLE;
    res.blue_byte    = res_wr ? encode(c[2]) : ENC_IDLE;
    stat.clearing    = (state == ST_CLEAR);
    stat.res_push    = (state == ST_OUT) && !res_full;
  end
endmodule

@@ hdl/led_frame_blend_gamma_encoder.sv @@
// Top level of the LED frame blend and gamma encoder.
`timescale 1ns / 1ps
// Items enter through a two-deep command queue and run one at a time in the
// back end; results leave through a two-deep result queue. After reset the
// frame history, MAX_FRAMES*MAX_LEDS entries (2048 by default), is cleared with
// full held high. Commit and table loads finish in the back end's idle state.
// A set pixel passes the map, gamma and output states; with blending it first
// reads each blended frame through the single history read port and divides
// the sums in the bit-serial divider. A skipped pixel goes straight to output.
// A full result queue stalls the back end.
module led_frame_blend_gamma_encoder #(
  parameter int MAX_LEDS = 256,
  parameter int MAX_FRAMES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] index,
  input  logic [1:0] channel,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] table_value,
  input  logic       map_skip,
  output logic       empty,
  input  logic       pop,
  output logic       written,
  output logic [7:0] physical_led,
  output logic [7:0] green_byte,
  output logic [7:0] red_byte,
  output logic [7:0] blue_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import lfbg_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  logic       cmd_empty;
  logic       cmd_pop;
  res_t       res;
  res_t       res_out;
  logic       res_full;
  back_stat_t stat;
  logic [$bits(res_t)-1:0] res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_frames <= '0;
      cfg.num_outputs  <= '0;
      cfg.gamma_enable <= GAMMA_ENABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLEND_FRAMES: cfg.blend_frames <= cfg_data[3:0];
        CFG_NUM_OUTPUTS:  cfg.num_outputs  <= cfg_data;
        CFG_GAMMA_ENABLE: cfg.gamma_enable <= cfg_data[2:0];
        CFG_UNUSED:       ;
      endcase
    end
  end

  lfbg_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .index(index), .channel(channel),
    .red(red), .green(green), .blue(blue),
    .table_value(table_value), .map_skip(map_skip),
    .clearing(stat.clearing), .cmd_pop(cmd_pop), .cmd(cmd), .cmd_empty(cmd_empty)
  );

  lfbg_back #(.MAX_LEDS(MAX_LEDS), .MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop), .res_full(res_full), .res(res), .stat(stat)
  );

  lfbg_fifo #(.W($bits(res_t)), .DEPTH(2)) u_resq (
    .clk(clk), .rst(rst),
    .wr_en(stat.res_push), .wr_data(res), .full(res_full),
    .rd_en(pop), .rd_data(res_q), .empty(empty)
  );

  assign res_out      = res_t'(res_q);
  assign written      = res_out.written;
  assign physical_led = res_out.physical_led;
  assign green_byte   = res_out.green_byte;
  assign red_byte     = res_out.red_byte;
  assign blue_byte    = res_out.blue_byte;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    stat.res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_skip_bytes: assert property (@(posedge clk) disable iff (rst)
    (!empty && !written) |-> (physical_led == 8'h00 && green_byte == ENC_IDLE
      && red_byte == ENC_IDLE && blue_byte == ENC_IDLE))
    else $error("skipped pixel carries data");

  a_clear_blocks: assert property (@(posedge clk)
    $past(rst) |-> full)
    else $error("input open during history clear");
endmodule
